[design/bmp24_to_rgb565_stream_defines.svh]
// Assertion macros shared by the BMP stream decoder modules.
`ifndef BMP24_TO_RGB565_STREAM_DEFINES_SVH
`define BMP24_TO_RGB565_STREAM_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define B2R_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bmp24_to_rgb565_stream: assertion failed");
// Check a property on every clock edge, reset included.
`define B2R_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bmp24_to_rgb565_stream: assertion failed");
`else
`define B2R_ASSERT(lbl, prop)
`define B2R_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[design/b2r565_pkg.sv]
// Types and constants for the BMP 24-bit to RGB565 stream decoder.
package b2r565_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_GAP    = 3'd2,
    PH_PIXEL  = 3'd3,
    PH_PAD    = 3'd4
  } phase_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_PIXEL      = 2'd0,
    KIND_BAD_SIG    = 2'd1,
    KIND_BAD_FORMAT = 2'd2,
    KIND_BAD_OFFSET = 2'd3
  } kind_t;

  // One result item
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [15:0] colour;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        last_pixel;
  } result_t;

  // Header layout: index of the last byte of each field
  localparam logic [5:0] HDR_SIGNATURE = 6'd1;
  localparam logic [5:0] HDR_OFFSET    = 6'd13;
  localparam logic [5:0] HDR_WIDTH     = 6'd21;
  localparam logic [5:0] HDR_HEIGHT    = 6'd25;
  localparam logic [5:0] HDR_PLANES    = 6'd27;
  localparam logic [5:0] HDR_BPP       = 6'd29;
  localparam logic [5:0] HDR_COMPRESS  = 6'd33;

  localparam logic [31:0] HEADER_BYTES = 32'd34;
  localparam logic [15:0] BM_SIGNATURE = 16'h4D42;
  localparam logic [15:0] PLANES_ONE   = 16'd1;
  localparam logic [15:0] BPP_24       = 16'd24;

  // Configuration port
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam logic        REG_ORIGIN_X = 1'b0;
  localparam logic        REG_ORIGIN_Y = 1'b1;

endpackage

[design/b2r565_parser.sv]
// BMP header parser and pixel assembler: updates parse state per byte transfer.
`include "bmp24_to_rgb565_stream_defines.svh"
module b2r565_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_fire,
  input  logic [7:0]          data_byte,
  input  logic                file_start,
  input  logic [15:0]         origin_x,
  input  logic [15:0]         origin_y,
  output b2r565_pkg::result_t res
);

  b2r565_pkg::phase_t phase_r, phase_nxt, c_phase;
  logic [5:0]  count_r, count_nxt, c_count;
  logic [31:0] shift_r, shift_nxt, c_shift;
  logic [31:0] offset_r, offset_nxt, c_offset;
  logic [31:0] gap_r, gap_nxt, c_gap;
  logic [15:0] width_r, width_nxt, c_width;
  logic [15:0] height_r, height_nxt, c_height;
  logic        fmt_r, fmt_nxt, c_fmt;
  logic [15:0] col_r, col_nxt, c_col;
  logic [15:0] row_r, row_nxt, c_row;
  logic [1:0]  bip_r, bip_nxt, c_bip;
  logic [1:0]  pad_r, pad_nxt, c_pad;
  logic [7:0]  blue_r, blue_nxt, c_blue;
  logic [7:0]  green_r, green_nxt, c_green;
  logic [15:0] hi16;
  logic [15:0] col_inc;
  logic [15:0] row_inc;

  // Take the start-of-file values in place of the held state
  always_comb begin
    if (file_start) begin
      c_phase  = b2r565_pkg::PH_HEADER;
      c_count  = '0;
      c_shift  = '0;
      c_offset = '0;
      c_gap    = '0;
      c_width  = '0;
      c_height = '0;
      c_fmt    = 1'b1;
      c_col    = '0;
      c_row    = '0;
      c_bip    = '0;
      c_pad    = '0;
      c_blue   = '0;
      c_green  = '0;
    end else begin
      c_phase  = phase_r;
      c_count  = count_r;
      c_shift  = shift_r;
      c_offset = offset_r;
      c_gap    = gap_r;
      c_width  = width_r;
      c_height = height_r;
      c_fmt    = fmt_r;
      c_col    = col_r;
      c_row    = row_r;
      c_bip    = bip_r;
      c_pad    = pad_r;
      c_blue   = blue_r;
      c_green  = green_r;
    end
  end

  // Upper half of the header word once this byte is shifted in
  assign hi16    = {data_byte, c_shift[31:24]};
  assign col_inc = c_col + 16'd1;
  assign row_inc = c_row + 16'd1;

  // Next state and result for the byte on the input
  always_comb begin
    phase_nxt  = c_phase;
    count_nxt  = c_count;
    shift_nxt  = c_shift;
    offset_nxt = c_offset;
    gap_nxt    = c_gap;
    width_nxt  = c_width;
    height_nxt = c_height;
    fmt_nxt    = c_fmt;
    col_nxt    = c_col;
    row_nxt    = c_row;
    bip_nxt    = c_bip;
    pad_nxt    = c_pad;
    blue_nxt   = c_blue;
    green_nxt  = c_green;
    res        = '0;
    res.kind   = b2r565_pkg::KIND_PIXEL;

    case (c_phase)
      b2r565_pkg::PH_HEADER: begin
        shift_nxt = {data_byte, c_shift[31:8]};
        count_nxt = c_count + 6'd1;
        case (c_count)
          b2r565_pkg::HDR_SIGNATURE: begin
            if (hi16 != b2r565_pkg::BM_SIGNATURE) begin
              phase_nxt = b2r565_pkg::PH_IDLE;
              res.valid = 1'b1;
              res.kind  = b2r565_pkg::KIND_BAD_SIG;
            end
          end
          b2r565_pkg::HDR_OFFSET: begin
            offset_nxt = shift_nxt;
          end
          b2r565_pkg::HDR_WIDTH: begin
            if (hi16 != 16'd0) fmt_nxt = 1'b0;
            width_nxt = shift_nxt[15:0];
          end
          b2r565_pkg::HDR_HEIGHT: begin
            if (hi16 != 16'd0) fmt_nxt = 1'b0;
            height_nxt = shift_nxt[15:0];
          end
          b2r565_pkg::HDR_PLANES: begin
            if (hi16 != b2r565_pkg::PLANES_ONE) fmt_nxt = 1'b0;
          end
          b2r565_pkg::HDR_BPP: begin
            if (hi16 != b2r565_pkg::BPP_24) fmt_nxt = 1'b0;
          end
          b2r565_pkg::HDR_COMPRESS: begin
            fmt_nxt = c_fmt && (shift_nxt == 32'd0);
            if (!fmt_nxt) begin
              phase_nxt = b2r565_pkg::PH_IDLE;
              res.valid = 1'b1;
              res.kind  = b2r565_pkg::KIND_BAD_FORMAT;
            end else if (c_offset < b2r565_pkg::HEADER_BYTES) begin
              phase_nxt = b2r565_pkg::PH_IDLE;
              res.valid = 1'b1;
              res.kind  = b2r565_pkg::KIND_BAD_OFFSET;
            end else if (c_width == 16'd0 || c_height == 16'd0) begin
              phase_nxt = b2r565_pkg::PH_IDLE;
            end else begin
              gap_nxt   = c_offset - b2r565_pkg::HEADER_BYTES;
              phase_nxt = (gap_nxt == 32'd0) ? b2r565_pkg::PH_PIXEL
                                             : b2r565_pkg::PH_GAP;
            end
          end
          default: begin
          end
        endcase
      end
      b2r565_pkg::PH_GAP: begin
        // Skip bytes up to the pixel data
        gap_nxt = c_gap - 32'd1;
        if (gap_nxt == 32'd0) phase_nxt = b2r565_pkg::PH_PIXEL;
      end
      b2r565_pkg::PH_PIXEL: begin
        if (c_bip == 2'd0) begin
          blue_nxt = data_byte;
          bip_nxt  = 2'd1;
        end else if (c_bip == 2'd1) begin
          green_nxt = data_byte;
          bip_nxt   = 2'd2;
        end else begin
          // Red byte closes the pixel
          bip_nxt        = 2'd0;
          res.valid      = 1'b1;
          res.colour     = {data_byte[7:3], c_green[7:2], c_blue[7:3]};
          res.pos_x      = origin_x + c_col;
          res.pos_y      = origin_y + c_height - 16'd1 - c_row;
          res.last_pixel = (c_row == c_height - 16'd1) && (c_col == c_width - 16'd1);
          col_nxt        = col_inc;
          if (col_inc == c_width) begin
            col_nxt = '0;
            row_nxt = row_inc;
            if (row_inc == c_height) begin
              phase_nxt = b2r565_pkg::PH_IDLE;
            end else begin
              pad_nxt = c_width[1:0];
              if (c_width[1:0] != 2'd0) phase_nxt = b2r565_pkg::PH_PAD;
            end
          end
        end
      end
      b2r565_pkg::PH_PAD: begin
        // Drop row padding
        pad_nxt = c_pad - 2'd1;
        if (pad_nxt == 2'd0) phase_nxt = b2r565_pkg::PH_PIXEL;
      end
      default: begin
      end
    endcase
  end

  // Advance the parse state on each byte transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= b2r565_pkg::PH_IDLE;
      count_r  <= '0;
      shift_r  <= '0;
      offset_r <= '0;
      gap_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      fmt_r    <= 1'b1;
      col_r    <= '0;
      row_r    <= '0;
      bip_r    <= '0;
      pad_r    <= '0;
      blue_r   <= '0;
      green_r  <= '0;
    end else if (byte_fire) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      shift_r  <= shift_nxt;
      offset_r <= offset_nxt;
      gap_r    <= gap_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      fmt_r    <= fmt_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      bip_r    <= bip_nxt;
      pad_r    <= pad_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
    end
  end

  `B2R_ASSERT(a_pad_nonzero, (phase_r == b2r565_pkg::PH_PAD) |-> (pad_r != 2'd0))
  `B2R_ASSERT(a_pixel_dims, (phase_r == b2r565_pkg::PH_PIXEL) |-> (|width_r && |height_r))
  `B2R_ASSERT(a_pad_dims, (phase_r == b2r565_pkg::PH_PAD) |-> (|width_r && |height_r))
  `B2R_ASSERT(a_byte_slot, bip_r != 2'd3)
  `B2R_ASSERT(a_gap_nonzero, (phase_r == b2r565_pkg::PH_GAP) |-> (gap_r != 32'd0))

endmodule

[design/bmp24_to_rgb565_stream.sv]
// Top level: BMP 24-bit byte stream to RGB565 pixels with screen coordinates.
//
//   channel   direction  handshake            payload
//   in_       in         in_valid/in_ready    in_data_byte, in_file_start
//   out_      out        out_valid/out_ready  out_kind, out_colour, out_pos_x,
//                                             out_pos_y, out_last_pixel
//   config    in         psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// One byte is taken per cycle unless a full output register that is not taken
// holds in_ready low; the output register takes a result in the cycle after
// the byte that completes it. The byte is parsed in a single pass between the
// parse state and the output register. Reset (rst_n low, synchronous) idles
// the parser until a byte with in_file_start set, and clears both origins.
`include "bmp24_to_rgb565_stream_defines.svh"
module bmp24_to_rgb565_stream (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_data_byte,
  input  logic                                  in_file_start,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_kind,
  output logic [15:0]                           out_colour,
  output logic signed [15:0]                    out_pos_x,
  output logic signed [15:0]                    out_pos_y,
  output logic                                  out_last_pixel,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [b2r565_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  logic                signed [15:0] origin_x_r;
  logic                signed [15:0] origin_y_r;
  logic                cfg_write;
  logic                in_fire;
  b2r565_pkg::result_t res;
  b2r565_pkg::result_t out_r;
  logic                out_valid_r;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == b2r565_pkg::REG_ORIGIN_X) origin_x_r <= pwdata[15:0];
      else                                      origin_y_r <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == b2r565_pkg::REG_ORIGIN_X) prdata = {{16{origin_x_r[15]}}, origin_x_r};
    else                                      prdata = {{16{origin_y_r[15]}}, origin_y_r};
  end

  // Accept a byte whenever the output register is free or being emptied
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  b2r565_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_fire  (in_fire),
    .data_byte  (in_data_byte),
    .file_start (in_file_start),
    .origin_x   (origin_x_r),
    .origin_y   (origin_y_r),
    .res        (res)
  );

  // Output register: load a new result, drop a taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_colour     = out_r.colour;
  assign out_pos_x      = $signed(out_r.pos_x);
  assign out_pos_y      = $signed(out_r.pos_y);
  assign out_last_pixel = out_r.last_pixel;

  `B2R_ASSERT(a_ready_when_empty, !out_valid_r |-> in_ready)
  `B2R_ASSERT(a_no_overwrite, (out_valid_r && !out_ready) |-> !in_fire)
  `B2R_ASSERT(a_error_payload, (out_valid_r && out_r.kind != b2r565_pkg::KIND_PIXEL) |-> (out_r.colour == 16'd0 && out_r.last_pixel == 1'b0 && out_r.pos_x == 16'd0 && out_r.pos_y == 16'd0))
  `B2R_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r)

endmodule
